// File: hw/rtl/ps2kt_pkg.sv
// Shared constants, codes and helper functions for the PS/2 keyboard transmitter.
package ps2kt_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_BANKS   = 4;
  localparam int BANK_SEL_W  = 2;
  localparam int BANK_DEPTH  = QUEUE_DEPTH / NUM_BANKS;
  localparam int BANK_ADDR_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 1'd1;

  localparam logic [7:0] HALF_BIT_RESET = 8'd4;
  localparam logic [7:0] GAP_RESET      = 8'd8;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_PRESS   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PRE  = 2'd1;
  localparam logic [1:0] PH_BITS = 2'd2;
  localparam logic [1:0] PH_POST = 2'd3;

  localparam logic [3:0] BIT_START  = 4'd0;
  localparam logic [3:0] BIT_LAST_D = 4'd8;
  localparam logic [3:0] BIT_PARITY = 4'd9;
  localparam logic [3:0] BITS_FRAME = 4'd11;

  localparam logic [8:0] TICK_MAX = 9'd511;

  localparam logic [7:0] CODE_EXT     = 8'he0;
  localparam logic [7:0] CODE_RELEASE = 8'hf0;

  typedef logic [QIDX_W-1:0]      qidx_t;
  typedef logic [QCNT_W-1:0]      qcnt_t;
  typedef logic [BANK_ADDR_W-1:0] baddr_t;

  typedef struct packed {
    logic valid;
    logic release_evt;
    logic [7:0] code;
  } key_evt_t;

  typedef struct packed {
    logic nonempty;
    logic overflow;
  } q_stat_t;

  typedef struct packed {
    logic line_clock;
    logic line_data;
    logic busy;
  } line_t;

  function automatic logic is_nav(input logic [7:0] code);
    return code inside {8'h71, 8'h6c, 8'h69, 8'h7d, 8'h7a,
                        8'h75, 8'h72, 8'h74, 8'h6b, 8'h70};
  endfunction

  function automatic qidx_t idx_inc(input qidx_t idx);
    return (idx == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

endpackage

// File: hw/rtl/ps2kt_if.sv
// Valid/ready channel interfaces for key requests and line samples.
interface ps2kt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] scan_code;

  modport source (output valid, output mode, output scan_code, input ready);
  modport sink (input valid, input mode, input scan_code, output ready);
endinterface

interface ps2kt_out_if;
  logic valid;
  logic ready;
  logic line_clock;
  logic line_data;
  logic busy_res;
  logic overflow;

  modport source (output valid, output line_clock, output line_data,
                  output busy_res, output overflow, input ready);
  modport sink (input valid, input line_clock, input line_data,
                input busy_res, input overflow, output ready);
endinterface

// File: hw/rtl/ps2kt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ps2kt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/ps2kt_queue.sv
// Scan-code byte queue: event expansion, four interleaved banks, head/tail/count.
module ps2kt_queue
  import ps2kt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  key_evt_t evt,
  input  logic     pop,
  output q_stat_t  stat,
  output logic [7:0] head_byte
);

  qidx_t head_r, head_nxt;
  qidx_t tail_r, tail_nxt;
  qcnt_t count_r, count_nxt;
  logic  ovf_r, ovf_nxt;
  logic [BANK_SEL_W-1:0] sel_r;

  logic       nav;
  logic [1:0] need;
  logic       fits;
  logic       push_ok;
  logic [7:0] byte_seq [4];
  qidx_t      addr_seq [4];
  logic [7:0] bank_rd [NUM_BANKS];

  always_comb begin
    nav  = is_nav(evt.code);
    need = 2'd1 + {1'b0, nav} + {1'b0, evt.release_evt};
    fits = ({1'b0, count_r} + (QCNT_W + 1)'(need)) <= (QCNT_W + 1)'(QUEUE_DEPTH);
    push_ok = evt.valid && fits;

    if (nav) begin
      byte_seq[0] = CODE_EXT;
      byte_seq[1] = evt.release_evt ? CODE_RELEASE : evt.code;
    end else begin
      byte_seq[0] = evt.release_evt ? CODE_RELEASE : evt.code;
      byte_seq[1] = evt.code;
    end
    byte_seq[2] = evt.code;
    byte_seq[3] = evt.code;

    addr_seq[0] = tail_r;
    addr_seq[1] = idx_inc(addr_seq[0]);
    addr_seq[2] = idx_inc(addr_seq[1]);
    addr_seq[3] = idx_inc(addr_seq[2]);

    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (evt.valid) begin
      if (fits) begin
        tail_nxt  = addr_seq[need];
        count_nxt = count_r + QCNT_W'(need);
      end else begin
        ovf_nxt = 1'b1;
      end
    end else if (pop) begin
      head_nxt  = idx_inc(head_r);
      count_nxt = count_r - 1'b1;
    end
  end

  // Consecutive slots land in distinct banks, so one event writes all its bytes at once.
  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
    logic [BANK_SEL_W-1:0] off;
    logic                  bank_we;
    logic                  bank_re;

    assign off     = BANK_SEL_W'(k) - tail_r[BANK_SEL_W-1:0];
    assign bank_we = push_ok && ({1'b0, off} < {1'b0, need});
    assign bank_re = pop && (head_r[BANK_SEL_W-1:0] == BANK_SEL_W'(k));

    ps2kt_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we),
      .waddr (baddr_t'(addr_seq[off] >> BANK_SEL_W)),
      .wdata (byte_seq[off]),
      .re    (bank_re),
      .raddr (baddr_t'(head_r >> BANK_SEL_W)),
      .rdata (bank_rd[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      sel_r   <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (pop) begin
        sel_r <= head_r[BANK_SEL_W-1:0];
      end
    end
  end

  assign stat.nonempty = (count_r != '0);
  assign stat.overflow = ovf_nxt;
  assign head_byte     = bank_rd[sel_r];

endmodule

// File: hw/rtl/ps2kt_framer.sv
// Frame sequencer: gap, start/data/parity/stop bits and line levels per tick.
module ps2kt_framer
  import ps2kt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tick,
  input  logic [7:0] half_cfg,
  input  logic [7:0] gap_cfg,
  input  logic       q_nonempty,
  input  logic [7:0] cur_byte,
  output logic       pop,
  output line_t      lines
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] bit_pos_r, bit_pos_nxt;
  logic [8:0] tick_r, tick_nxt;

  logic [7:0] half;
  logic [8:0] two_half;
  logic [9:0] tick_inc;
  logic [3:0] bit_inc;
  logic [2:0] data_idx;
  logic       bit_val;

  always_comb begin
    half     = (half_cfg == '0) ? 8'd1 : half_cfg;
    two_half = {half, 1'b0};

    phase_nxt   = phase_r;
    bit_pos_nxt = bit_pos_r;
    tick_nxt    = tick_r;
    pop         = 1'b0;

    if (phase_nxt == PH_POST && tick_nxt >= {1'b0, gap_cfg}) begin
      phase_nxt = PH_IDLE;
    end
    if (phase_nxt == PH_IDLE && q_nonempty) begin
      pop         = tick;
      phase_nxt   = PH_PRE;
      tick_nxt    = '0;
      bit_pos_nxt = BIT_START;
    end
    if (phase_nxt == PH_PRE && tick_nxt >= {1'b0, gap_cfg}) begin
      phase_nxt = PH_BITS;
      tick_nxt  = '0;
    end

    lines.busy = (phase_nxt != PH_IDLE);

    // Data bits need the popped byte, which is only read at least two ticks after the pop.
    data_idx = 3'(bit_pos_nxt - 4'd1);
    if (bit_pos_nxt == BIT_START) begin
      bit_val = 1'b0;
    end else if (bit_pos_nxt <= BIT_LAST_D) begin
      bit_val = cur_byte[data_idx];
    end else if (bit_pos_nxt == BIT_PARITY) begin
      bit_val = ~(^cur_byte);
    end else begin
      bit_val = 1'b1;
    end

    tick_inc = {1'b0, tick_nxt} + 10'd1;
    bit_inc  = bit_pos_nxt + 4'd1;

    lines.line_clock = 1'b1;
    lines.line_data  = 1'b1;
    case (phase_nxt)
      PH_BITS: begin
        lines.line_clock = (tick_nxt < {1'b0, half});
        lines.line_data  = bit_val;
        tick_nxt = tick_inc[8:0];
        if (tick_inc >= {1'b0, two_half}) begin
          tick_nxt    = '0;
          bit_pos_nxt = bit_inc;
          if (bit_inc >= BITS_FRAME) begin
            bit_pos_nxt = BIT_START;
            phase_nxt   = PH_POST;
          end
        end
      end
      PH_PRE, PH_POST: begin
        if (tick_nxt < TICK_MAX) begin
          tick_nxt = tick_inc[8:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_pos_r <= '0;
      tick_r    <= '0;
    end else if (tick) begin
      phase_r   <= phase_nxt;
      bit_pos_r <= bit_pos_nxt;
      tick_r    <= tick_nxt;
    end
  end

endmodule

// File: hw/rtl/ps2_keyboard_transmitter.sv
// Top level of the PS/2 keyboard transmitter: handshake, configuration, result register.
// A key press or release puts its one to three scan-code bytes into the 64-entry byte
// queue as it is taken (the queue is four interleaved RAM banks, one write port each),
// and a sample tick advances the frame sequencer and loads one line sample into the
// output register. A new request is taken every cycle unless a sample sits in the output
// register and the sink is not ready. Key requests produce no sample; an event that does
// not fit is dropped whole and sets the sticky overflow bit.
// Registers: index 0 sets ticks per half bit (0 acts as 1), index 1 the idle gap around
// each frame. The queue needs no clearing after reset.
module ps2_keyboard_transmitter
  import ps2kt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ps2kt_in_if.sink              in_ch,
  ps2kt_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [7:0] half_r;
  logic [7:0] gap_r;

  logic     accept;
  logic     tick;
  key_evt_t evt;
  q_stat_t  q_stat;
  logic [7:0] head_byte;
  logic     pop;
  line_t    lines;

  logic out_valid_r, out_valid_nxt;
  logic line_clock_r, line_data_r, busy_r, ovf_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign tick        = accept && (in_ch.mode == MODE_TICK);

  assign evt.valid       = accept && (in_ch.mode == MODE_PRESS ||
                                      in_ch.mode == MODE_RELEASE);
  assign evt.release_evt = (in_ch.mode == MODE_RELEASE);
  assign evt.code        = in_ch.scan_code;

  ps2kt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt       (evt),
    .pop       (pop),
    .stat      (q_stat),
    .head_byte (head_byte)
  );

  ps2kt_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .half_cfg   (half_r),
    .gap_cfg    (gap_r),
    .q_nonempty (q_stat.nonempty),
    .cur_byte   (head_byte),
    .pop        (pop),
    .lines      (lines)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_BIT_RESET;
      gap_r  <= GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_BIT: half_r <= cfg_wdata;
        CFG_GAP:      gap_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (tick) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the sample until it is taken; a new one only loads on a tick.
  always_ff @(posedge clk) begin
    if (tick) begin
      line_clock_r <= lines.line_clock;
      line_data_r  <= lines.line_data;
      busy_r       <= lines.busy;
      ovf_r        <= q_stat.overflow;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_clock = line_clock_r;
  assign out_ch.line_data  = line_data_r;
  assign out_ch.busy_res   = busy_r;
  assign out_ch.overflow   = ovf_r;

endmodule

// File: hw/rtl/ps2kt_checker.sv
// Port-level assertions for the PS/2 keyboard transmitter, bound to the top level.
module ps2kt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic line_clock,
  input logic line_data,
  input logic busy_res,
  input logic overflow
);

  // A waiting sample blocks new requests.
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while a sample waits");

  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(line_clock) &&
      $stable(line_data) && $stable(busy_res) && $stable(overflow))
    else $error("stalled sample changed");

  // Lines only drop low inside a frame.
  a_low_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!line_clock || !line_data) |-> busy_res)
    else $error("line low while not busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("sample valid right after reset");

endmodule

bind ps2_keyboard_transmitter ps2kt_checker u_ps2kt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .line_clock (out_ch.line_clock),
  .line_data  (out_ch.line_data),
  .busy_res   (out_ch.busy_res),
  .overflow   (out_ch.overflow)
);
